// ----- rtl/ftr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fence timeline retirer package
// Sizes, codes, stored entry layouts and small helpers shared by the block.
// ----------------------------------------------------------------------------
package ftr_pkg;

    localparam int NUM_RINGS   = 4;
    localparam int QUEUE_DEPTH = 8;
    localparam int TASK_SLOTS  = 64;

    localparam int RING_W  = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
    localparam int QPOS_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W  = $clog2(TASK_SLOTS);
    localparam int QWORDS  = NUM_RINGS * QUEUE_DEPTH;
    localparam int QADDR_W = (QWORDS > 1) ? $clog2(QWORDS) : 1;

    // Opcodes of an input item.
    typedef enum logic [1:0] {
        OP_ENQ_TASK  = 2'd0,
        OP_ENQ_FENCE = 2'd1,
        OP_COMPLETE  = 2'd2,
        OP_POLL      = 2'd3
    } t_opcode;

    // Kinds of result.
    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_FENCE = 2'd1,
        KIND_TASK  = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    // Error codes.
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_QUEUE_FULL = 3'd1,
        ERR_TABLE_FULL = 3'd2,
        ERR_UNKNOWN    = 3'd3,
        ERR_DONE_TWICE = 3'd4,
        ERR_POLL       = 3'd5
    } t_err;

    // One timeline entry: a fence id, or the table slot of a task.
    typedef struct packed {
        logic        is_fence;
        logic [63:0] payload;
    } t_qentry;

    // One task table entry.
    typedef struct packed {
        logic [31:0]       id;
        logic [RING_W-1:0] ring;
        logic              done;
    } t_tentry;

    // Fold a 2-bit ring number into range by repeated compare and subtract.
    function automatic logic [RING_W-1:0] ring_fold(input logic [1:0] r);
        logic [4:0] v;
        v = {3'b000, r};
        for (int k = 0; k < 3; k++) begin
            if (v >= 5'(NUM_RINGS)) begin
                v = v - 5'(NUM_RINGS);
            end
        end
        return v[RING_W-1:0];
    endfunction

    // Ring number as shown on the 2-bit result field.
    function automatic logic [1:0] ring_out(input logic [RING_W-1:0] r);
        logic [RING_W+1:0] w;
        w = {2'b00, r};
        return w[1:0];
    endfunction

endpackage

// ----- rtl/fence_timeline_retirer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fence timeline retirer
// Per-ring timelines of tasks and fences, retired in order from each head.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Results appear for one
// cycle each under o_result_valid and cannot be held off; the final result of a
// command carries o_last. Some commands are answered in the cycle after they
// are taken and never raise busy: an enqueue into a full queue, a poll in async
// mode, and a fence enqueue outside async mode. Every other command keeps busy
// high until its final result is driven. Enqueue task scans the valid bits one
// slot per cycle. A completion scans the task table one slot at a time through
// its single read port, reading in S_MRD and comparing in S_MCMP. Retirement
// walks each ring it visits from its head: a fence passes through S_WRD and
// S_WEV, a dropped task through S_WRD, S_WEV and S_WTK. A ring that runs empty
// ends its walk in S_WRD, and a ring that stops at an unfinished task ends it in
// S_WTK. The closing acknowledge is driven from S_FIN.
module fence_timeline_retirer
    import ftr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [1:0]  i_ring_number,
    input  logic [63:0] i_fence_id,
    input  logic [31:0] i_task_id,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    output logic        o_result_valid,
    output logic [1:0]  o_result_kind,
    output logic [2:0]  o_error_code,
    output logic [31:0] o_assigned_task,
    output logic [63:0] o_signaled_fence,
    output logic [1:0]  o_signal_ring,
    output logic        o_last
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_FREE = 8'b0000_0010,
        S_MRD  = 8'b0000_0100,
        S_MCMP = 8'b0000_1000,
        S_WRD  = 8'b0001_0000,
        S_WEV  = 8'b0010_0000,
        S_WTK  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic                r_async;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    logic [RING_W-1:0]   r_ring, n_ring;
    logic                r_poll, n_poll;
    logic [31:0]         r_next, n_next;
    logic [31:0]         r_tid, n_tid;
    logic [QPOS_W-1:0]   r_head [NUM_RINGS];
    logic [QCNT_W-1:0]   r_count [NUM_RINGS];
    logic [TASK_SLOTS-1:0] r_valid;

    logic                r_out_valid, n_out_valid;
    t_kind               r_kind, n_kind;
    t_err                r_err, n_err;
    logic [31:0]         r_atask, n_atask;
    logic [63:0]         r_fence, n_fence;
    logic [1:0]          r_sring, n_sring;
    logic                r_last, n_last;

    // Queue RAM ports.
    logic                q_we;
    logic [QADDR_W-1:0]  q_waddr, q_raddr;
    t_qentry             q_wdata, q_rdata;

    // Task table RAM ports.
    logic                t_we;
    logic [SLOT_W-1:0]   t_waddr, t_raddr;
    t_tentry             t_wdata, t_rdata;

    // Queue bookkeeping controls.
    logic                push, advance, v_set, v_clr;
    logic [RING_W-1:0]   in_ring, p_ring;
    logic                p_full, w_empty, match, ring_last;
    logic [QPOS_W-1:0]   tail_pos;

    assign in_ring   = ring_fold(i_ring_number);
    assign p_ring    = (r_state == S_IDLE) ? in_ring : r_ring;
    assign p_full    = (r_count[p_ring] >= QCNT_W'(QUEUE_DEPTH));
    assign w_empty   = (r_count[r_ring] == '0);
    assign match     = r_valid[r_idx] && (t_rdata.id == r_tid);
    assign ring_last = (r_ring == RING_W'(NUM_RINGS - 1));

    // Tail position of the ring being pushed.
    always_comb begin
        int t;
        t = int'(r_head[p_ring]) + int'(r_count[p_ring]);
        if (t >= QUEUE_DEPTH) begin
            t = t - QUEUE_DEPTH;
        end
        tail_pos = QPOS_W'(t);
    end

    assign q_waddr = QADDR_W'(int'(p_ring) * QUEUE_DEPTH + int'(tail_pos));
    assign q_raddr = QADDR_W'(int'(r_ring) * QUEUE_DEPTH + int'(r_head[r_ring]));
    assign t_raddr = (r_state == S_WEV) ? q_rdata.payload[SLOT_W-1:0] : r_idx;
    assign t_waddr = r_idx;

    ftr_ram #(.WIDTH($bits(t_qentry)), .DEPTH(QWORDS), .AW(QADDR_W)) u_queue (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    ftr_ram #(.WIDTH($bits(t_tentry)), .DEPTH(TASK_SLOTS), .AW(SLOT_W)) u_tasks (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    // Sequencer: command decode, slot scans and the retirement walk.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_ring      = r_ring;
        n_poll      = r_poll;
        n_next      = r_next;
        n_tid       = r_tid;
        n_out_valid = 1'b0;
        n_kind      = KIND_ACK;
        n_err       = ERR_NONE;
        n_atask     = '0;
        n_fence     = '0;
        n_sring     = '0;
        n_last      = 1'b0;
        push        = 1'b0;
        advance     = 1'b0;
        v_set       = 1'b0;
        v_clr       = 1'b0;
        q_we        = 1'b0;
        q_wdata     = '{is_fence: 1'b1, payload: i_fence_id};
        t_we        = 1'b0;
        t_wdata     = '{id: r_next, ring: r_ring, done: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_ring = in_ring;
                    n_idx  = '0;
                    n_tid  = i_task_id;
                    n_poll = 1'b0;
                    case (t_opcode'(i_opcode))
                        OP_ENQ_TASK: begin
                            if (p_full) begin
                                n_out_valid = 1'b1;
                                n_kind      = KIND_ERROR;
                                n_err       = ERR_QUEUE_FULL;
                                n_last      = 1'b1;
                            end else begin
                                n_state = S_FREE;
                            end
                        end
                        OP_ENQ_FENCE: begin
                            if (p_full) begin
                                n_out_valid = 1'b1;
                                n_kind      = KIND_ERROR;
                                n_err       = ERR_QUEUE_FULL;
                                n_last      = 1'b1;
                            end else begin
                                q_we = 1'b1;
                                push = 1'b1;
                                if (r_async) begin
                                    n_state = S_WRD;
                                end else begin
                                    n_out_valid = 1'b1;
                                    n_last      = 1'b1;
                                end
                            end
                        end
                        OP_COMPLETE: begin
                            n_state = S_MRD;
                        end
                        default: begin
                            if (r_async) begin
                                n_out_valid = 1'b1;
                                n_kind      = KIND_ERROR;
                                n_err       = ERR_POLL;
                                n_last      = 1'b1;
                            end else begin
                                n_ring  = '0;
                                n_poll  = 1'b1;
                                n_state = S_WRD;
                            end
                        end
                    endcase
                end
            end

            // Find the lowest free task slot.
            S_FREE: begin
                if (!r_valid[r_idx]) begin
                    v_set       = 1'b1;
                    t_we        = 1'b1;
                    q_we        = 1'b1;
                    q_wdata     = '{is_fence: 1'b0, payload: 64'(r_idx)};
                    push        = 1'b1;
                    n_out_valid = 1'b1;
                    n_kind      = KIND_TASK;
                    n_atask     = r_next;
                    n_last      = 1'b1;
                    n_next      = r_next + 32'd1;
                    n_state     = S_IDLE;
                end else if (r_idx == SLOT_W'(TASK_SLOTS - 1)) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_ERROR;
                    n_err       = ERR_TABLE_FULL;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end

            S_MRD: begin
                n_state = S_MCMP;
            end

            // Compare one table entry against the reported id.
            S_MCMP: begin
                if (match) begin
                    if (t_rdata.done) begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_ERROR;
                        n_err       = ERR_DONE_TWICE;
                        n_last      = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        t_we    = 1'b1;
                        t_wdata = '{id: t_rdata.id, ring: t_rdata.ring, done: 1'b1};
                        n_ring  = t_rdata.ring;
                        n_state = r_async ? S_WRD : S_FIN;
                    end
                end else if (r_idx == SLOT_W'(TASK_SLOTS - 1)) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_ERROR;
                    n_err       = ERR_UNKNOWN;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_idx   = r_idx + SLOT_W'(1);
                    n_state = S_MRD;
                end
            end

            // Head read is issued here; an empty ring ends its walk.
            S_WRD: begin
                if (!w_empty) begin
                    n_state = S_WEV;
                end else if (r_poll && !ring_last) begin
                    n_ring = r_ring + RING_W'(1);
                end else begin
                    n_state = S_FIN;
                end
            end

            // A fence is signaled at once; a task needs its done flag.
            S_WEV: begin
                if (q_rdata.is_fence) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_FENCE;
                    n_fence     = q_rdata.payload;
                    n_sring     = ring_out(r_ring);
                    advance     = 1'b1;
                    n_state     = S_WRD;
                end else begin
                    n_idx   = q_rdata.payload[SLOT_W-1:0];
                    n_state = S_WTK;
                end
            end

            S_WTK: begin
                if (t_rdata.done) begin
                    v_clr   = 1'b1;
                    advance = 1'b1;
                    n_state = S_WRD;
                end else if (r_poll && !ring_last) begin
                    n_ring  = r_ring + RING_W'(1);
                    n_state = S_WRD;
                end else begin
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                n_out_valid = 1'b1;
                n_last      = 1'b1;
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, queue pointers and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_async     <= 1'b0;
            r_next      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_poll      <= 1'b0;
            for (int k = 0; k < NUM_RINGS; k++) begin
                r_head[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_next      <= n_next;
            r_out_valid <= n_out_valid;
            r_poll      <= n_poll;
            if (i_cfg_we) begin
                r_async <= i_cfg_wdata;
            end
            if (push) begin
                r_count[p_ring] <= r_count[p_ring] + QCNT_W'(1);
            end
            if (advance) begin
                r_count[r_ring] <= r_count[r_ring] - QCNT_W'(1);
                if (r_head[r_ring] == QPOS_W'(QUEUE_DEPTH - 1)) begin
                    r_head[r_ring] <= '0;
                end else begin
                    r_head[r_ring] <= r_head[r_ring] + QPOS_W'(1);
                end
            end
            if (v_set || v_clr) begin
                r_valid[r_idx] <= v_set;
            end
        end
    end

    // Working registers and result payload.
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_ring  <= n_ring;
        r_tid   <= n_tid;
        r_kind  <= n_kind;
        r_err   <= n_err;
        r_atask <= n_atask;
        r_fence <= n_fence;
        r_sring <= n_sring;
        r_last  <= n_last;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_result_valid   = r_out_valid;
    assign o_result_kind    = r_kind;
    assign o_error_code     = r_err;
    assign o_assigned_task  = r_atask;
    assign o_signaled_fence = r_fence;
    assign o_signal_ring    = r_sring;
    assign o_last           = r_last;

endmodule

// ----- rtl/ftr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fence timeline retirer RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ftr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- sim/fence_timeline_retirer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fence timeline retirer testbench
// Sends directed and random commands, predicts every result from a timeline
// model of its own, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module fence_timeline_retirer_tb;
    import ftr_pkg::*;

    typedef struct {
        t_kind       kind;
        t_err        code;
        logic [31:0] task_num;
        logic [63:0] fence;
        logic [1:0]  ring;
        logic        last;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_opcode = '0;
    logic [1:0]  i_ring_number = '0;
    logic [63:0] i_fence_id = '0;
    logic [31:0] i_task_id = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        o_result_valid;
    logic [1:0]  o_result_kind;
    logic [2:0]  o_error_code;
    logic [31:0] o_assigned_task;
    logic [63:0] o_signaled_fence;
    logic [1:0]  o_signal_ring;
    logic        o_last;

    // Timeline state kept by the testbench.
    bit          mode_async;
    bit          ent_fence [NUM_RINGS][QUEUE_DEPTH];
    logic [63:0] ent_data  [NUM_RINGS][QUEUE_DEPTH];
    int          tl_head   [NUM_RINGS];
    int          tl_count  [NUM_RINGS];
    bit          slot_used [TASK_SLOTS];
    logic [31:0] slot_id   [TASK_SLOTS];
    int          slot_ring [TASK_SLOTS];
    bit          slot_done [TASK_SLOTS];
    logic [31:0] next_id;

    t_outcome    pending_results[$];
    int          mismatches = 0;

    fence_timeline_retirer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_ring_number    (i_ring_number),
        .i_fence_id       (i_fence_id),
        .i_task_id        (i_task_id),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_result_valid   (o_result_valid),
        .o_result_kind    (o_result_kind),
        .o_error_code     (o_error_code),
        .o_assigned_task  (o_assigned_task),
        .o_signaled_fence (o_signaled_fence),
        .o_signal_ring    (o_signal_ring),
        .o_last           (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Generous limit on the whole run.
    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic add_outcome(input t_kind k, input t_err e, input logic [31:0] t,
                               input logic [63:0] f, input logic [1:0] r,
                               input logic l);
        t_outcome o;
        o.kind = k;
        o.code = e;
        o.task_num = t;
        o.fence = f;
        o.ring = r;
        o.last = l;
        pending_results.push_back(o);
    endtask

    // Walk one timeline from its head until the first unfinished task.
    task automatic retire_timeline(input int r);
        int pos;
        int slot;
        while (tl_count[r] > 0) begin
            pos = tl_head[r];
            if (ent_fence[r][pos]) begin
                add_outcome(KIND_FENCE, ERR_NONE, '0, ent_data[r][pos], 2'(r), 1'b0);
            end else begin
                slot = int'(ent_data[r][pos] % TASK_SLOTS);
                if (!slot_done[slot]) break;
                slot_used[slot] = 1'b0;
            end
            tl_head[r] = (tl_head[r] + 1) % QUEUE_DEPTH;
            tl_count[r]--;
        end
    endtask

    task automatic append_entry(input int r, input bit is_f, input logic [63:0] d);
        int pos;
        pos = (tl_head[r] + tl_count[r]) % QUEUE_DEPTH;
        ent_fence[r][pos] = is_f;
        ent_data[r][pos] = d;
        tl_count[r]++;
    endtask

    // Work out the results of one accepted command.
    task automatic predict_command(input t_opcode op, input logic [1:0] rn,
                                   input logic [63:0] fid, input logic [31:0] tid);
        int r;
        int slot;
        r = int'(rn) % NUM_RINGS;
        slot = -1;
        case (op)
            OP_ENQ_TASK: begin
                if (tl_count[r] >= QUEUE_DEPTH) begin
                    add_outcome(KIND_ERROR, ERR_QUEUE_FULL, '0, '0, '0, 1'b1);
                    return;
                end
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    if (!slot_used[i]) begin
                        slot = i;
                        break;
                    end
                end
                if (slot < 0) begin
                    add_outcome(KIND_ERROR, ERR_TABLE_FULL, '0, '0, '0, 1'b1);
                    return;
                end
                slot_used[slot] = 1'b1;
                slot_id[slot] = next_id;
                slot_ring[slot] = r;
                slot_done[slot] = 1'b0;
                append_entry(r, 1'b0, 64'(slot));
                add_outcome(KIND_TASK, ERR_NONE, next_id, '0, '0, 1'b1);
                next_id++;
            end
            OP_ENQ_FENCE: begin
                if (tl_count[r] >= QUEUE_DEPTH) begin
                    add_outcome(KIND_ERROR, ERR_QUEUE_FULL, '0, '0, '0, 1'b1);
                    return;
                end
                append_entry(r, 1'b1, fid);
                if (mode_async) retire_timeline(r);
                add_outcome(KIND_ACK, ERR_NONE, '0, '0, '0, 1'b1);
            end
            OP_COMPLETE: begin
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    if (slot_used[i] && slot_id[i] == tid) begin
                        slot = i;
                        break;
                    end
                end
                if (slot < 0) begin
                    add_outcome(KIND_ERROR, ERR_UNKNOWN, '0, '0, '0, 1'b1);
                    return;
                end
                if (slot_done[slot]) begin
                    add_outcome(KIND_ERROR, ERR_DONE_TWICE, '0, '0, '0, 1'b1);
                    return;
                end
                slot_done[slot] = 1'b1;
                if (mode_async) retire_timeline(slot_ring[slot]);
                add_outcome(KIND_ACK, ERR_NONE, '0, '0, '0, 1'b1);
            end
            default: begin
                if (mode_async) begin
                    add_outcome(KIND_ERROR, ERR_POLL, '0, '0, '0, 1'b1);
                    return;
                end
                for (int i = 0; i < NUM_RINGS; i++) retire_timeline(i);
                add_outcome(KIND_ACK, ERR_NONE, '0, '0, '0, 1'b1);
            end
        endcase
    endtask

    // Result checker: every strobed result is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_outcome o;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                o = pending_results.pop_front();
                if (o_result_kind !== o.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", o_result_kind, o.kind));
                if (o_error_code !== o.code)
                    report_mismatch($sformatf("error %0d, expected %0d", o_error_code, o.code));
                if (o_assigned_task !== o.task_num)
                    report_mismatch($sformatf("task id %h, expected %h",
                                              o_assigned_task, o.task_num));
                if (o_signaled_fence !== o.fence)
                    report_mismatch($sformatf("fence %h, expected %h",
                                              o_signaled_fence, o.fence));
                if (o_signal_ring !== o.ring)
                    report_mismatch($sformatf("ring %0d, expected %0d", o_signal_ring, o.ring));
                if (o_last !== o.last)
                    report_mismatch($sformatf("last %0d, expected %0d", o_last, o.last));
            end
        end
    end

    // Drive one command and hold it until the block takes it.
    task automatic send_command(input t_opcode op, input logic [1:0] rn,
                                input logic [63:0] fid, input logic [31:0] tid);
        @(negedge i_clk);
        i_opcode = op;
        i_ring_number = rn;
        i_fence_id = fid;
        i_task_id = tid;
        start = 1'b1;
        do begin
            @(posedge i_clk);
        end while (busy);
        predict_command(op, rn, fid, tid);
    endtask

    // Random sender gap after a transfer.
    task automatic maybe_idle(input int pct);
        if ($urandom_range(99) < pct) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(5)) @(negedge i_clk);
        end
    endtask

    // Stop sending and wait until every expected result has arrived.
    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_async(input bit v);
        drain_results();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        mode_async = v;
    endtask

    // Basic ordering: a fence waits behind an unfinished task until a poll.
    task automatic test_ordering();
        send_command(OP_ENQ_TASK, 2'd0, '0, '0);
        send_command(OP_ENQ_FENCE, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        send_command(OP_POLL, 2'd0, '0, '0);
        send_command(OP_COMPLETE, 2'd0, '0, 32'd0);
        send_command(OP_POLL, 2'd3, '0, '0);
        send_command(OP_COMPLETE, 2'd0, '0, 32'd0);
        send_command(OP_ENQ_TASK, 2'd3, '0, '0);
        send_command(OP_COMPLETE, 2'd1, '0, 32'd1);
        send_command(OP_COMPLETE, 2'd1, '0, 32'd1);
        send_command(OP_POLL, 2'd0, '0, '0);
    endtask

    // A full timeline refuses both fences and tasks.
    task automatic test_full_timeline();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_command(OP_ENQ_FENCE, 2'd3, {$urandom, $urandom}, '0);
        send_command(OP_ENQ_FENCE, 2'd3, 64'd0, '0);
        send_command(OP_ENQ_TASK, 2'd3, '0, '0);
        send_command(OP_POLL, 2'd1, '0, '0);
    endtask

    // Async mode: immediate retirement, poll refused, unknown ids rejected.
    task automatic test_async();
        write_async(1'b1);
        send_command(OP_ENQ_TASK, 2'd2, '0, '0);
        send_command(OP_ENQ_FENCE, 2'd2, 64'h8000_0000_0000_0001, '0);
        send_command(OP_COMPLETE, 2'd0, '0, next_id - 32'd1);
        send_command(OP_ENQ_FENCE, 2'd2, 64'h0123_4567_89AB_CDEF, '0);
        send_command(OP_POLL, 2'd2, '0, '0);
        send_command(OP_COMPLETE, 2'd0, '0, 32'hFFFF_FFFF);
        drain_results();
    endtask

    // Random commands of all four kinds, completions mostly of live tasks, under a given sender gap rate.
    task automatic test_random(input int count, input int idle_pct);
        int cand[$];
        int sel;
        t_opcode op;
        logic [31:0] tid;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 35) op = OP_ENQ_TASK;
            else if (sel < 60) op = OP_ENQ_FENCE;
            else if (sel < 90) op = OP_COMPLETE;
            else op = OP_POLL;
            tid = $urandom;
            cand.delete();
            for (int i = 0; i < TASK_SLOTS; i++)
                if (slot_used[i]) cand.push_back(i);
            if (op == OP_COMPLETE && cand.size() != 0 && $urandom_range(9) < 8)
                tid = slot_id[cand[$urandom_range(cand.size() - 1)]];
            send_command(op, 2'($urandom), {$urandom, $urandom}, tid);
            maybe_idle(idle_pct);
        end
    endtask

    initial begin
        mode_async = 1'b0;
        next_id = '0;
        for (int r = 0; r < NUM_RINGS; r++) begin
            tl_head[r] = 0;
            tl_count[r] = 0;
        end
        for (int i = 0; i < TASK_SLOTS; i++) slot_used[i] = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_ordering();
        test_full_timeline();
        test_async();
        write_async(1'b0);
        test_random(40, 0);
        write_async(1'b1);
        test_random(40, 71);
        write_async(1'b0);
        test_random(40, 18);
        write_async(1'b1);
        test_random(40, 0);

        drain_results();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
